### hw/rtl/tddc_pkg.sv
// Package for the texture descriptor decode and check block.
// Holds the payload types, error codes and tile and dimension codes.
// No dependencies; used by the channel interfaces and the top level.
package tddc_pkg;

	typedef struct packed {
		logic [31:0] word0;
		logic [31:0] word1;
		logic [31:0] word2;
		logic [31:0] word3;
		logic [31:0] word4;
		logic [31:0] word5;
		logic [31:0] word6;
		logic [31:0] word7;
	} desc_t;

	typedef struct packed {
		logic [4:0]  error_code;
		logic [47:0] base_address;
		logic [14:0] width;
		logic [14:0] height;
		logic [12:0] depth_or_last_slice;
		logic [12:0] base_slice;
		logic [12:0] mip_levels;
		logic [5:0]  tile_and_dim;
		logic [8:0]  pixel_format;
		logic [11:0] channel_selects;
		logic [47:0] dcc_address;
		logic        dcc_alpha_msb;
	} result_t;

	localparam logic [4:0] ERR_NONE          = 5'd0;
	localparam logic [4:0] ERR_NULL_BASE     = 5'd1;
	localparam logic [4:0] ERR_BAD_SELECT    = 5'd2;
	localparam logic [4:0] ERR_MIN_LOD       = 5'd3;
	localparam logic [4:0] ERR_CORNER        = 5'd4;
	localparam logic [4:0] ERR_PRT_DEFAULT   = 5'd5;
	localparam logic [4:0] ERR_ARRAY_PITCH   = 5'd6;
	localparam logic [4:0] ERR_MSAA          = 5'd7;
	localparam logic [4:0] ERR_BC_SWIZZLE    = 5'd8;
	localparam logic [4:0] ERR_BASE_PAST_LAST = 5'd9;
	localparam logic [4:0] ERR_UNKNOWN_TILE  = 5'd10;
	localparam logic [4:0] ERR_UNKNOWN_TYPE  = 5'd11;
	localparam logic [4:0] ERR_BASE_PAST_MAX = 5'd12;
	localparam logic [4:0] ERR_XOR_ALIGN     = 5'd13;
	localparam logic [4:0] ERR_SHAPE_1D      = 5'd14;
	localparam logic [4:0] ERR_SHAPE_2D      = 5'd15;
	localparam logic [4:0] ERR_BASE_3D       = 5'd16;
	localparam logic [4:0] ERR_ARRAY_BASE    = 5'd17;
	localparam logic [4:0] ERR_CUBE_SQUARE   = 5'd18;
	localparam logic [4:0] ERR_CUBE_BASE     = 5'd19;
	localparam logic [4:0] ERR_CUBE_SIX      = 5'd20;

	// Raw tile mode field values and their dense codes.
	localparam logic [4:0] TILE_RAW_LINEAR  = 5'h00;
	localparam logic [4:0] TILE_RAW_STD256  = 5'h01;
	localparam logic [4:0] TILE_RAW_STD4K   = 5'h05;
	localparam logic [4:0] TILE_RAW_STD64K  = 5'h09;
	localparam logic [4:0] TILE_RAW_Z64K_X  = 5'h18;
	localparam logic [4:0] TILE_RAW_S64K_X  = 5'h19;
	localparam logic [4:0] TILE_RAW_D64K_X  = 5'h1a;
	localparam logic [4:0] TILE_RAW_R64K_X  = 5'h1b;

	localparam logic [2:0] TILE_LINEAR  = 3'd0;
	localparam logic [2:0] TILE_STD256  = 3'd1;
	localparam logic [2:0] TILE_STD4K   = 3'd2;
	localparam logic [2:0] TILE_STD64K  = 3'd3;
	localparam logic [2:0] TILE_Z64K_X  = 3'd4;
	localparam logic [2:0] TILE_S64K_X  = 3'd5;
	localparam logic [2:0] TILE_D64K_X  = 3'd6;
	localparam logic [2:0] TILE_R64K_X  = 3'd7;

	// Raw resource type values and their dense dimension codes.
	localparam logic [3:0] TYPE_RAW_1D       = 4'd8;
	localparam logic [3:0] TYPE_RAW_2D       = 4'd9;
	localparam logic [3:0] TYPE_RAW_3D       = 4'd10;
	localparam logic [3:0] TYPE_RAW_CUBE     = 4'd11;
	localparam logic [3:0] TYPE_RAW_2D_ARRAY = 4'd13;

	localparam logic [2:0] DIM_1D       = 3'd0;
	localparam logic [2:0] DIM_2D       = 3'd1;
	localparam logic [2:0] DIM_3D       = 3'd2;
	localparam logic [2:0] DIM_CUBE     = 3'd3;
	localparam logic [2:0] DIM_2D_ARRAY = 3'd4;

	// Reciprocal of six in 16 fractional bits; exact floor for values up to 8192.
	localparam logic [13:0] RECIP6 = 14'd10923;

endpackage

### hw/rtl/tddc_desc_if.sv
// Valid/ready channel that carries one image descriptor per beat.
// Depends on tddc_pkg for the payload type.
interface tddc_desc_if;
	logic            valid;
	logic            ready;
	tddc_pkg::desc_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/tddc_result_if.sv
// Valid/ready channel that carries one decoded result per beat.
// Depends on tddc_pkg for the payload type.
interface tddc_result_if;
	logic              valid;
	logic              ready;
	tddc_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/texture_descriptor_decode_check_core.sv
// Top level of the texture descriptor decode and check block.
// Depends on tddc_pkg, tddc_desc_if and tddc_result_if.
//
// Usage:
//   desc carries one 8-dword image descriptor per beat; result carries the
//   decoded fields and an error code, one beat for every descriptor, in order.
//   A nonzero error code names the first failed check, and then every other
//   result field is zero.
//   A descriptor is captured in the input register and its result in the
//   result register, which offers the beat on result. The decode and all
//   checks are one pass of logic between the input register and the result
//   register, so a descriptor can be taken in every cycle while the receiver
//   takes every result, one per cycle sustained.
//   When the receiver stalls, the result register holds its beat and the
//   input register still takes one more descriptor; desc.ready drops only
//   when both registers are full.
//   Reset clears both valid flags; no result is pending after reset.
module texture_descriptor_decode_check_core (
	input  logic                 clk,
	input  logic                 arst_n,
	tddc_desc_if.sink            desc,
	tddc_result_if.source        result
);

	tddc_pkg::desc_t   desc_s1;
	logic              valid_s1;
	tddc_pkg::result_t res_s2;
	logic              valid_s2;
	tddc_pkg::result_t res_d;
	logic              adv_s2;

	assign adv_s2     = !valid_s2 || result.ready;
	assign desc.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (desc.ready) begin
				valid_s1 <= desc.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc.ready) begin
			desc_s1 <= desc.payload;
		end
		if (adv_s2) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = res_s2;

	// Field extraction.
	logic [39:0] base40;
	logic [47:0] base_addr;
	logic [11:0] min_lod;
	logic [8:0]  format;
	logic [14:0] width;
	logic [14:0] height;
	logic [11:0] sels;
	logic [3:0]  base_lvl;
	logic [3:0]  last_lvl;
	logic [3:0]  last_clamped;
	logic [4:0]  tile_raw;
	logic [2:0]  bc_swz;
	logic [3:0]  type_raw;
	logic [12:0] depth;
	logic [12:0] base_arr;
	logic [3:0]  pitch;
	logic [3:0]  max_mip;
	logic        corner;
	logic        prt;
	logic        msaa;
	logic        meta_on;
	logic        alpha;
	logic [39:0] meta40;

	assign base40    = {desc_s1.word1[7:0], desc_s1.word0};
	assign base_addr = {base40, 8'h00};
	assign min_lod   = desc_s1.word1[19:8];
	assign format    = desc_s1.word1[28:20];
	assign width     = {1'b0, desc_s1.word2[11:0], desc_s1.word1[31:30]} + 15'd1;
	assign height    = {1'b0, desc_s1.word2[27:14]} + 15'd1;
	assign sels      = desc_s1.word3[11:0];
	assign base_lvl  = desc_s1.word3[15:12];
	assign last_lvl  = desc_s1.word3[19:16];
	assign tile_raw  = desc_s1.word3[24:20];
	assign bc_swz    = desc_s1.word3[27:25];
	assign type_raw  = desc_s1.word3[31:28];
	assign depth     = desc_s1.word4[12:0];
	assign base_arr  = desc_s1.word4[28:16];
	assign pitch     = desc_s1.word5[3:0];
	assign max_mip   = desc_s1.word5[7:4];
	assign corner    = desc_s1.word5[23];
	assign prt       = desc_s1.word5[26];
	assign msaa      = desc_s1.word6[10];
	assign meta_on   = desc_s1.word6[21];
	assign alpha     = desc_s1.word6[22];
	assign meta40    = {desc_s1.word7, desc_s1.word6[31:24]};

	assign last_clamped = (last_lvl > max_mip) ? max_mip : last_lvl;

	// Channel selects: only 2 and 3 are illegal codes.
	logic sel_bad;
	always_comb begin
		sel_bad = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (!(sels[3*i +: 3] inside {3'd0, 3'd1, [3'd4:3'd7]})) begin
				sel_bad = 1'b1;
			end
		end
	end

	logic [2:0] tile;
	logic       tile_ok;
	always_comb begin
		tile_ok = 1'b1;
		case (tile_raw)
			tddc_pkg::TILE_RAW_LINEAR: tile = tddc_pkg::TILE_LINEAR;
			tddc_pkg::TILE_RAW_STD256: tile = tddc_pkg::TILE_STD256;
			tddc_pkg::TILE_RAW_STD4K:  tile = tddc_pkg::TILE_STD4K;
			tddc_pkg::TILE_RAW_STD64K: tile = tddc_pkg::TILE_STD64K;
			tddc_pkg::TILE_RAW_Z64K_X: tile = tddc_pkg::TILE_Z64K_X;
			tddc_pkg::TILE_RAW_S64K_X: tile = tddc_pkg::TILE_S64K_X;
			tddc_pkg::TILE_RAW_D64K_X: tile = tddc_pkg::TILE_D64K_X;
			tddc_pkg::TILE_RAW_R64K_X: tile = tddc_pkg::TILE_R64K_X;
			default: begin
				tile    = tddc_pkg::TILE_LINEAR;
				tile_ok = 1'b0;
			end
		endcase
	end

	logic [2:0] dim;
	logic       dim_ok;
	always_comb begin
		dim_ok = 1'b1;
		case (type_raw)
			tddc_pkg::TYPE_RAW_1D:       dim = tddc_pkg::DIM_1D;
			tddc_pkg::TYPE_RAW_2D:       dim = tddc_pkg::DIM_2D;
			tddc_pkg::TYPE_RAW_3D:       dim = tddc_pkg::DIM_3D;
			tddc_pkg::TYPE_RAW_CUBE:     dim = tddc_pkg::DIM_CUBE;
			tddc_pkg::TYPE_RAW_2D_ARRAY: dim = tddc_pkg::DIM_2D_ARRAY;
			default: begin
				dim    = tddc_pkg::DIM_1D;
				dim_ok = 1'b0;
			end
		endcase
	end

	// Cube slice count modulo six. The count is only judged once the base
	// slice is known not to pass the depth, so it lies in 1..8192.
	logic [13:0] slices;
	logic [27:0] slices_prod;
	logic [11:0] slices_div6;
	logic [13:0] slices_rem;
	assign slices      = {1'b0, depth} - {1'b0, base_arr} + 14'd1;
	assign slices_prod = slices * tddc_pkg::RECIP6;
	assign slices_div6 = slices_prod[27:16];
	assign slices_rem  = slices - ({slices_div6, 2'b00} + {1'b0, slices_div6, 1'b0});

	logic xor_tile;
	assign xor_tile = (tile == tddc_pkg::TILE_Z64K_X) || (tile == tddc_pkg::TILE_S64K_X)
		|| (tile == tddc_pkg::TILE_D64K_X) || (tile == tddc_pkg::TILE_R64K_X);

	logic [4:0] err;
	always_comb begin
		err = tddc_pkg::ERR_NONE;
		if (base40 == 40'd0) begin
			err = tddc_pkg::ERR_NULL_BASE;
		end else if (sel_bad) begin
			err = tddc_pkg::ERR_BAD_SELECT;
		end else if (min_lod != 12'd0) begin
			err = tddc_pkg::ERR_MIN_LOD;
		end else if (corner) begin
			err = tddc_pkg::ERR_CORNER;
		end else if (prt) begin
			err = tddc_pkg::ERR_PRT_DEFAULT;
		end else if (pitch != 4'd0) begin
			err = tddc_pkg::ERR_ARRAY_PITCH;
		end else if (msaa) begin
			err = tddc_pkg::ERR_MSAA;
		end else if (bc_swz != 3'd0) begin
			err = tddc_pkg::ERR_BC_SWIZZLE;
		end else if (base_lvl > last_lvl) begin
			err = tddc_pkg::ERR_BASE_PAST_LAST;
		end else if (!tile_ok) begin
			err = tddc_pkg::ERR_UNKNOWN_TILE;
		end else if (!dim_ok) begin
			err = tddc_pkg::ERR_UNKNOWN_TYPE;
		end else if (base_lvl > max_mip) begin
			err = tddc_pkg::ERR_BASE_PAST_MAX;
		end else if (xor_tile && (base_addr[15:0] != 16'd0)) begin
			err = tddc_pkg::ERR_XOR_ALIGN;
		end else begin
			case (dim)
				tddc_pkg::DIM_1D: begin
					if (height != 15'd1 || depth != 13'd0 || base_arr != 13'd0) begin
						err = tddc_pkg::ERR_SHAPE_1D;
					end
				end
				tddc_pkg::DIM_2D: begin
					if (depth != 13'd0 || base_arr != 13'd0) begin
						err = tddc_pkg::ERR_SHAPE_2D;
					end
				end
				tddc_pkg::DIM_3D: begin
					if (base_arr != 13'd0) begin
						err = tddc_pkg::ERR_BASE_3D;
					end
				end
				tddc_pkg::DIM_2D_ARRAY: begin
					if (base_arr > depth) begin
						err = tddc_pkg::ERR_ARRAY_BASE;
					end
				end
				default: begin
					if (width != height) begin
						err = tddc_pkg::ERR_CUBE_SQUARE;
					end else if (base_arr > depth) begin
						err = tddc_pkg::ERR_CUBE_BASE;
					end else if (slices_rem != 14'd0) begin
						err = tddc_pkg::ERR_CUBE_SIX;
					end
				end
			endcase
		end
	end

	always_comb begin
		res_d = '0;
		res_d.error_code = err;
		if (err == tddc_pkg::ERR_NONE) begin
			res_d.base_address        = base_addr;
			res_d.width               = width;
			res_d.height              = height;
			res_d.depth_or_last_slice = depth;
			res_d.base_slice          = base_arr;
			res_d.mip_levels          = {{1'b0, max_mip} + 5'd1, base_lvl, last_clamped};
			res_d.tile_and_dim        = {tile, dim};
			res_d.pixel_format        = format;
			res_d.channel_selects     = sels;
			res_d.dcc_address         = meta_on ? {meta40, 8'h00} : 48'd0;
			res_d.dcc_alpha_msb       = alpha;
		end
	end

	// An accepted descriptor always lands in the input register.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		desc.valid && desc.ready |=> valid_s1)
		else $error("accepted descriptor did not reach the input register");

	// A failed check leaves the base address, width, mip levels and DCC address at zero.
	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.error_code != tddc_pkg::ERR_NONE)
		|-> (res_s2.base_address == 48'd0) && (res_s2.width == 15'd0)
			&& (res_s2.mip_levels == 13'd0) && (res_s2.dcc_address == 48'd0))
		else $error("nonzero error code with nonzero decoded fields");

	// The clamped last level never reaches the mip count.
	a_last_level_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.error_code == tddc_pkg::ERR_NONE)
		|-> ({1'b0, res_s2.mip_levels[3:0]} < res_s2.mip_levels[12:8]))
		else $error("last mip level not clamped below the mip count");

endmodule

### sim/testbench.sv
// Self-checking testbench for texture_descriptor_decode_check_core.
// Depends on tddc_pkg, tddc_desc_if and tddc_result_if; predicts every result beat
// in a scoreboard class and drives both channels with random idles and stalls.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PER_PHASE = 456;
	localparam int IDLE_PCT [4] = '{0, 63, 0, 15};
	localparam int STALL_PCT [4] = '{0, 0, 63, 15};
	// The last four entries are the XOR-swizzled 64KB modes.
	localparam logic [4:0] TILE_RAW_CODES [8] = '{tddc_pkg::TILE_RAW_LINEAR,
		tddc_pkg::TILE_RAW_STD256, tddc_pkg::TILE_RAW_STD4K, tddc_pkg::TILE_RAW_STD64K,
		tddc_pkg::TILE_RAW_Z64K_X, tddc_pkg::TILE_RAW_S64K_X, tddc_pkg::TILE_RAW_D64K_X,
		tddc_pkg::TILE_RAW_R64K_X};

	class decode_scoreboard;
		tddc_pkg::result_t pending_results[$];
		int                accepted = 0;
		int                compared = 0;
		int                clean = 0;
		int                mismatches = 0;
		logic [20:0]       codes_seen = '0;

		function tddc_pkg::result_t decode_descriptor(tddc_pkg::desc_t d);
			tddc_pkg::result_t r;
			logic [47:0] base;
			logic [14:0] wid;
			logic [14:0] hgt;
			logic [3:0]  base_lvl;
			logic [3:0]  last_lvl;
			logic [3:0]  max_mip;
			logic [12:0] depth;
			logic [12:0] base_arr;
			logic [2:0]  tile;
			logic [2:0]  dim;
			logic        tile_ok;
			logic        dim_ok;
			logic        bad_sel;
			logic [4:0]  err;
			base = {d.word1[7:0], d.word0, 8'h00};
			wid = {1'b0, d.word2[11:0], d.word1[31:30]} + 15'd1;
			hgt = {1'b0, d.word2[27:14]} + 15'd1;
			base_lvl = d.word3[15:12];
			last_lvl = d.word3[19:16];
			max_mip = d.word5[7:4];
			depth = d.word4[12:0];
			base_arr = d.word4[28:16];
			// Selects 2 and 3 are the only illegal ones, both with upper bits 01.
			bad_sel = 1'b0;
			for (int i = 0; i < 4; i++) begin
				if (d.word3[3*i+1 +: 2] == 2'b01) bad_sel = 1'b1;
			end
			tile_ok = 1'b1;
			tile = tddc_pkg::TILE_LINEAR;
			case (d.word3[24:20])
				tddc_pkg::TILE_RAW_LINEAR: tile = tddc_pkg::TILE_LINEAR;
				tddc_pkg::TILE_RAW_STD256: tile = tddc_pkg::TILE_STD256;
				tddc_pkg::TILE_RAW_STD4K:  tile = tddc_pkg::TILE_STD4K;
				tddc_pkg::TILE_RAW_STD64K: tile = tddc_pkg::TILE_STD64K;
				tddc_pkg::TILE_RAW_Z64K_X: tile = tddc_pkg::TILE_Z64K_X;
				tddc_pkg::TILE_RAW_S64K_X: tile = tddc_pkg::TILE_S64K_X;
				tddc_pkg::TILE_RAW_D64K_X: tile = tddc_pkg::TILE_D64K_X;
				tddc_pkg::TILE_RAW_R64K_X: tile = tddc_pkg::TILE_R64K_X;
				default: tile_ok = 1'b0;
			endcase
			dim_ok = 1'b1;
			dim = tddc_pkg::DIM_1D;
			case (d.word3[31:28])
				tddc_pkg::TYPE_RAW_1D:       dim = tddc_pkg::DIM_1D;
				tddc_pkg::TYPE_RAW_2D:       dim = tddc_pkg::DIM_2D;
				tddc_pkg::TYPE_RAW_3D:       dim = tddc_pkg::DIM_3D;
				tddc_pkg::TYPE_RAW_CUBE:     dim = tddc_pkg::DIM_CUBE;
				tddc_pkg::TYPE_RAW_2D_ARRAY: dim = tddc_pkg::DIM_2D_ARRAY;
				default: dim_ok = 1'b0;
			endcase

			if (base == 48'd0) err = tddc_pkg::ERR_NULL_BASE;
			else if (bad_sel) err = tddc_pkg::ERR_BAD_SELECT;
			else if (d.word1[19:8] != 12'd0) err = tddc_pkg::ERR_MIN_LOD;
			else if (d.word5[23]) err = tddc_pkg::ERR_CORNER;
			else if (d.word5[26]) err = tddc_pkg::ERR_PRT_DEFAULT;
			else if (d.word5[3:0] != 4'd0) err = tddc_pkg::ERR_ARRAY_PITCH;
			else if (d.word6[10]) err = tddc_pkg::ERR_MSAA;
			else if (d.word3[27:25] != 3'd0) err = tddc_pkg::ERR_BC_SWIZZLE;
			else if (base_lvl > last_lvl) err = tddc_pkg::ERR_BASE_PAST_LAST;
			else if (!tile_ok) err = tddc_pkg::ERR_UNKNOWN_TILE;
			else if (!dim_ok) err = tddc_pkg::ERR_UNKNOWN_TYPE;
			else if (base_lvl > max_mip) err = tddc_pkg::ERR_BASE_PAST_MAX;
			else if (tile >= tddc_pkg::TILE_Z64K_X && base[15:0] != 16'd0)
				err = tddc_pkg::ERR_XOR_ALIGN;
			else if (dim == tddc_pkg::DIM_1D
				&& (hgt != 15'd1 || depth != 13'd0 || base_arr != 13'd0))
				err = tddc_pkg::ERR_SHAPE_1D;
			else if (dim == tddc_pkg::DIM_2D && (depth != 13'd0 || base_arr != 13'd0))
				err = tddc_pkg::ERR_SHAPE_2D;
			else if (dim == tddc_pkg::DIM_3D && base_arr != 13'd0)
				err = tddc_pkg::ERR_BASE_3D;
			else if (dim == tddc_pkg::DIM_2D_ARRAY && base_arr > depth)
				err = tddc_pkg::ERR_ARRAY_BASE;
			else if (dim == tddc_pkg::DIM_CUBE && wid != hgt)
				err = tddc_pkg::ERR_CUBE_SQUARE;
			else if (dim == tddc_pkg::DIM_CUBE && base_arr > depth)
				err = tddc_pkg::ERR_CUBE_BASE;
			else if (dim == tddc_pkg::DIM_CUBE
				&& (int'(depth) - int'(base_arr) + 1) % 6 != 0)
				err = tddc_pkg::ERR_CUBE_SIX;
			else err = tddc_pkg::ERR_NONE;

			r = '0;
			r.error_code = err;
			if (err == tddc_pkg::ERR_NONE) begin
				if (last_lvl > max_mip) last_lvl = max_mip;
				r.base_address = base;
				r.width = wid;
				r.height = hgt;
				r.depth_or_last_slice = depth;
				r.base_slice = base_arr;
				r.mip_levels = {5'({1'b0, max_mip} + 5'd1), base_lvl, last_lvl};
				r.tile_and_dim = {tile, dim};
				r.pixel_format = d.word1[28:20];
				r.channel_selects = d.word3[11:0];
				r.dcc_address = d.word6[21] ? {d.word7, d.word6[31:24], 8'h00} : 48'd0;
				r.dcc_alpha_msb = d.word6[22];
			end
			return r;
		endfunction

		function void note_descriptor(tddc_pkg::desc_t d);
			pending_results.push_back(decode_descriptor(d));
			accepted++;
		endfunction

		function void check_result(tddc_pkg::result_t got);
			tddc_pkg::result_t want;
			string             bad;
			bad = "";
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("decode check: result beat with none pending: %h", got);
				return;
			end
			want = pending_results.pop_front();
			compared++;
			codes_seen[want.error_code] = 1'b1;
			if (want.error_code == tddc_pkg::ERR_NONE) clean++;
			if (got.error_code !== want.error_code) bad = {bad, " error_code"};
			if (got.base_address !== want.base_address) bad = {bad, " base_address"};
			if (got.width !== want.width) bad = {bad, " width"};
			if (got.height !== want.height) bad = {bad, " height"};
			if (got.depth_or_last_slice !== want.depth_or_last_slice)
				bad = {bad, " depth_or_last_slice"};
			if (got.base_slice !== want.base_slice) bad = {bad, " base_slice"};
			if (got.mip_levels !== want.mip_levels) bad = {bad, " mip_levels"};
			if (got.tile_and_dim !== want.tile_and_dim) bad = {bad, " tile_and_dim"};
			if (got.pixel_format !== want.pixel_format) bad = {bad, " pixel_format"};
			if (got.channel_selects !== want.channel_selects)
				bad = {bad, " channel_selects"};
			if (got.dcc_address !== want.dcc_address) bad = {bad, " dcc_address"};
			if (got.dcc_alpha_msb !== want.dcc_alpha_msb) bad = {bad, " dcc_alpha_msb"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("decode check: result %0d differs in%s", compared, bad);
					$display("  expected %h", want);
					$display("  actual   %h", got);
				end
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	int               send_idle_pct;
	int               ready_stall_pct;
	decode_scoreboard board;

	tddc_desc_if   desc_ch();
	tddc_result_if result_ch();

	texture_descriptor_decode_check_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.desc   (desc_ch),
		.result (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("texture_descriptor_decode_check_core: mismatch");
		$finish;
	end

	// Builds a descriptor that passes every check except the one named by target.
	function automatic tddc_pkg::desc_t make_descriptor(input logic [4:0] target);
		tddc_pkg::desc_t d;
		logic [2:0] dim;
		logic [4:0] tile_raw;
		logic [3:0] type_raw;
		logic       x_tile;
		int         max_mip;
		int         base_lvl;
		int         last_lvl;
		int         depth_v;
		int         base_arr_v;
		int         count;
		int         k;
		for (int i = 0; i < 8; i++) d[32*i +: 32] = $urandom();
		case (target)
			tddc_pkg::ERR_SHAPE_1D: dim = tddc_pkg::DIM_1D;
			tddc_pkg::ERR_SHAPE_2D: dim = tddc_pkg::DIM_2D;
			tddc_pkg::ERR_BASE_3D: dim = tddc_pkg::DIM_3D;
			tddc_pkg::ERR_ARRAY_BASE: dim = tddc_pkg::DIM_2D_ARRAY;
			tddc_pkg::ERR_CUBE_SQUARE, tddc_pkg::ERR_CUBE_BASE, tddc_pkg::ERR_CUBE_SIX:
				dim = tddc_pkg::DIM_CUBE;
			default: dim = 3'($urandom_range(tddc_pkg::DIM_2D_ARRAY));
		endcase

		if (target == tddc_pkg::ERR_UNKNOWN_TILE) begin
			do tile_raw = 5'($urandom_range(31));
			while (tile_raw inside {tddc_pkg::TILE_RAW_LINEAR, tddc_pkg::TILE_RAW_STD256,
				tddc_pkg::TILE_RAW_STD4K, tddc_pkg::TILE_RAW_STD64K,
				tddc_pkg::TILE_RAW_Z64K_X, tddc_pkg::TILE_RAW_S64K_X,
				tddc_pkg::TILE_RAW_D64K_X, tddc_pkg::TILE_RAW_R64K_X});
		end else if (target == tddc_pkg::ERR_XOR_ALIGN) begin
			tile_raw = TILE_RAW_CODES[$urandom_range(7, 4)];
		end else begin
			tile_raw = TILE_RAW_CODES[$urandom_range(7)];
		end
		x_tile = tile_raw inside {tddc_pkg::TILE_RAW_Z64K_X, tddc_pkg::TILE_RAW_S64K_X,
			tddc_pkg::TILE_RAW_D64K_X, tddc_pkg::TILE_RAW_R64K_X};

		if (target == tddc_pkg::ERR_UNKNOWN_TYPE) begin
			do type_raw = 4'($urandom_range(15));
			while (type_raw inside {tddc_pkg::TYPE_RAW_1D, tddc_pkg::TYPE_RAW_2D,
				tddc_pkg::TYPE_RAW_3D, tddc_pkg::TYPE_RAW_CUBE,
				tddc_pkg::TYPE_RAW_2D_ARRAY});
		end else begin
			case (dim)
				tddc_pkg::DIM_1D: type_raw = tddc_pkg::TYPE_RAW_1D;
				tddc_pkg::DIM_2D: type_raw = tddc_pkg::TYPE_RAW_2D;
				tddc_pkg::DIM_3D: type_raw = tddc_pkg::TYPE_RAW_3D;
				tddc_pkg::DIM_CUBE: type_raw = tddc_pkg::TYPE_RAW_CUBE;
				default: type_raw = tddc_pkg::TYPE_RAW_2D_ARRAY;
			endcase
		end

		// The swizzled modes need a 64KB-aligned base, so address bits 15..8 stay clear.
		if (x_tile) d.word0[7:0] = 8'h00;
		if (target == tddc_pkg::ERR_XOR_ALIGN) d.word0[7:0] = 8'($urandom_range(255, 1));
		if ({d.word1[7:0], d.word0} == 40'd0) d.word0[31] = 1'b1;
		if (target == tddc_pkg::ERR_NULL_BASE) begin
			d.word0 = 32'd0;
			d.word1[7:0] = 8'd0;
		end

		for (int i = 0; i < 4; i++) begin
			k = $urandom_range(5);
			d.word3[3*i +: 3] = (k < 2) ? 3'(k) : 3'(k + 2);
		end
		if (target == tddc_pkg::ERR_BAD_SELECT) begin
			k = $urandom_range(3);
			d.word3[3*k +: 3] = 3'($urandom_range(3, 2));
		end

		if (target == tddc_pkg::ERR_BASE_PAST_LAST) begin
			max_mip = $urandom_range(15);
			last_lvl = $urandom_range(14);
			base_lvl = $urandom_range(15, last_lvl + 1);
		end else if (target == tddc_pkg::ERR_BASE_PAST_MAX) begin
			max_mip = $urandom_range(14);
			base_lvl = $urandom_range(15, max_mip + 1);
			last_lvl = $urandom_range(15, base_lvl);
		end else begin
			max_mip = $urandom_range(15);
			base_lvl = $urandom_range(max_mip);
			last_lvl = $urandom_range(15, base_lvl);
		end

		d.word1[19:8] = (target == tddc_pkg::ERR_MIN_LOD) ?
			12'($urandom_range(4095, 1)) : 12'd0;
		d.word3[15:12] = 4'(base_lvl);
		d.word3[19:16] = 4'(last_lvl);
		d.word3[24:20] = tile_raw;
		d.word3[27:25] = (target == tddc_pkg::ERR_BC_SWIZZLE) ?
			3'($urandom_range(7, 1)) : 3'd0;
		d.word3[31:28] = type_raw;
		d.word5[3:0] = (target == tddc_pkg::ERR_ARRAY_PITCH) ?
			4'($urandom_range(15, 1)) : 4'd0;
		d.word5[7:4] = 4'(max_mip);
		d.word5[23] = (target == tddc_pkg::ERR_CORNER);
		d.word5[26] = (target == tddc_pkg::ERR_PRT_DEFAULT);
		d.word6[10] = (target == tddc_pkg::ERR_MSAA);

		depth_v = 0;
		base_arr_v = 0;
		case (dim)
			tddc_pkg::DIM_1D: d.word2[27:14] = 14'd0;
			tddc_pkg::DIM_3D: depth_v = $urandom_range(8191);
			tddc_pkg::DIM_2D_ARRAY: begin
				depth_v = $urandom_range(8191);
				base_arr_v = $urandom_range(depth_v);
			end
			tddc_pkg::DIM_CUBE: begin
				d.word2[27:14] = {d.word2[11:0], d.word1[31:30]};
				base_arr_v = $urandom_range(8186);
				count = 6 * $urandom_range((8192 - base_arr_v) / 6, 1);
				depth_v = base_arr_v + count - 1;
			end
			default: ;
		endcase

		case (target)
			tddc_pkg::ERR_SHAPE_1D: begin
				case ($urandom_range(2))
					0: d.word2[27:14] = 14'($urandom_range(16383, 1));
					1: depth_v = $urandom_range(8191, 1);
					default: base_arr_v = $urandom_range(8191, 1);
				endcase
			end
			tddc_pkg::ERR_SHAPE_2D: begin
				if ($urandom_range(1) == 0) depth_v = $urandom_range(8191, 1);
				else base_arr_v = $urandom_range(8191, 1);
			end
			tddc_pkg::ERR_BASE_3D: base_arr_v = $urandom_range(8191, 1);
			tddc_pkg::ERR_ARRAY_BASE, tddc_pkg::ERR_CUBE_BASE: begin
				depth_v = $urandom_range(8190);
				base_arr_v = $urandom_range(8191, depth_v + 1);
			end
			tddc_pkg::ERR_CUBE_SQUARE:
				d.word2[27:14] = d.word2[27:14] ^ 14'($urandom_range(16383, 1));
			tddc_pkg::ERR_CUBE_SIX: begin
				base_arr_v = $urandom_range(4000);
				count = $urandom_range(4000, 1);
				if (count % 6 == 0) count++;
				depth_v = base_arr_v + count - 1;
			end
			default: ;
		endcase
		d.word4[12:0] = 13'(depth_v);
		d.word4[28:16] = 13'(base_arr_v);
		return d;
	endfunction

	task automatic send_descriptor(input tddc_pkg::desc_t d);
		while ($urandom_range(99) < send_idle_pct) begin
			desc_ch.valid <= 1'b0;
			@(posedge clk);
		end
		desc_ch.valid <= 1'b1;
		desc_ch.payload <= d;
		@(posedge clk);
		while (!desc_ch.ready) @(posedge clk);
	endtask

	// Holds the sender off until every predicted result beat has been checked.
	task automatic wait_for_drain();
		desc_ch.valid <= 1'b0;
		do @(posedge clk);
		while (board.outstanding() != 0);
	endtask

	always @(posedge clk) begin
		if (!arst_n) result_ch.ready <= 1'b0;
		else result_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (desc_ch.valid && desc_ch.ready) board.note_descriptor(desc_ch.payload);
			if (result_ch.valid && result_ch.ready) board.check_result(result_ch.payload);
		end
	end

	initial begin
		tddc_pkg::desc_t item;
		int              pick;
		board = new();
		arst_n = 1'b0;
		desc_ch.valid = 1'b0;
		desc_ch.payload = '0;
		result_ch.ready = 1'b0;
		send_idle_pct = 0;
		ready_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: all-zero and all-one words, the smallest and largest legal
		// descriptors, then one descriptor aimed at each error code.
		send_descriptor('0);
		send_descriptor('1);
		send_descriptor({32'h0000_0001, 32'h0, 32'h0,
			{tddc_pkg::TYPE_RAW_1D, 3'd0, tddc_pkg::TILE_RAW_LINEAR, 4'h0, 4'h0, 12'h000},
			32'h0, 32'h0, 32'h0, 32'h0});
		send_descriptor({32'hffff_ffff, 32'hfff0_00ff, 32'h0fff_cfff,
			{tddc_pkg::TYPE_RAW_CUBE, 3'd0, tddc_pkg::TILE_RAW_LINEAR, 4'hf, 4'hf, 12'hfff},
			{3'd0, 13'h1ffa, 3'd0, 13'h1fff}, 32'h0000_00f0, 32'hff60_0000, 32'hffff_ffff});
		for (int c = tddc_pkg::ERR_NONE; c <= tddc_pkg::ERR_CUBE_SIX; c++)
			send_descriptor(make_descriptor(5'(c)));
		wait_for_drain();

		// Random: mostly legal descriptors, three in ten aimed at one failing check,
		// and some raw noise, under four idle and stall mixes.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = IDLE_PCT[p];
			ready_stall_pct = STALL_PCT[p];
			repeat (RANDOM_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					for (int i = 0; i < 8; i++) item[32*i +: 32] = $urandom();
				end else if (pick < 40) begin
					item = make_descriptor(5'($urandom_range(tddc_pkg::ERR_CUBE_SIX,
						tddc_pkg::ERR_NULL_BASE)));
				end else begin
					item = make_descriptor(tddc_pkg::ERR_NONE);
				end
				send_descriptor(item);
			end
			wait_for_drain();
		end

		repeat (4) @(posedge clk);
		$display("decode check: %0d descriptors sent under four idle/stall mixes,",
			board.accepted);
		$display("  %0d checked, %0d legal, %0d of 21 result codes reached, %0d differing",
			board.compared, board.clean, $countones(board.codes_seen), board.mismatches);
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("texture_descriptor_decode_check_core: match");
		end else begin
			$display("texture_descriptor_decode_check_core: mismatch");
		end
		$finish;
	end

endmodule
